// ===== rtl/core/ralloc_pkg.sv =====
// ----------------------------------------------------------------------------
// ralloc_pkg
// Shared constants and types for the meeting room allocator.
// ----------------------------------------------------------------------------
package ralloc_pkg;

    localparam int MAX_ROOMS  = 16;
    localparam int ROOM_W     = $clog2(MAX_ROOMS);
    localparam int NUM_W      = 5;
    localparam int IN_TIME_W  = 32;
    localparam int TIME_W     = 48;
    localparam int USES_W     = 16;
    localparam int ENTRY_W    = TIME_W + USES_W;
    localparam int ROOM_OUT_W = 4;

    localparam logic [TIME_W-1:0] TIME_MAX = '1;
    localparam logic [USES_W-1:0] USES_MAX = '1;
    localparam logic [NUM_W-1:0]  NUM_RESET = NUM_W'(16);

    // One read beat coming back from the room memory
    typedef struct packed {
        logic              vld;
        logic              first;
        logic              last;
        logic [ROOM_W-1:0] idx;
    } beat_t;

    // Running results of one scan over the active rooms
    typedef struct packed {
        logic              found;
        logic [ROOM_W-1:0] free_idx;
        logic [USES_W-1:0] free_uses;
        logic [ROOM_W-1:0] min_idx;
        logic [TIME_W-1:0] min_finish;
        logic [USES_W-1:0] min_uses;
        logic [ROOM_W-1:0] best_idx;
        logic [USES_W-1:0] best_uses;
    } scan_res_t;

endpackage

// ===== rtl/core/ralloc_ram.sv =====
// ----------------------------------------------------------------------------
// ralloc_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module ralloc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== rtl/core/ralloc_scan.sv =====
// ----------------------------------------------------------------------------
// ralloc_scan
// Walks the read beats of one scan: first free room, earliest finish and
// first-index most-used room.
// ----------------------------------------------------------------------------
module ralloc_scan (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  ralloc_pkg::beat_t                  beat,
    input  logic [ralloc_pkg::TIME_W-1:0]      finish,
    input  logic [ralloc_pkg::USES_W-1:0]      uses,
    input  logic [ralloc_pkg::IN_TIME_W-1:0]   start_time,
    output ralloc_pkg::scan_res_t              res
);

    ralloc_pkg::scan_res_t res_reg, res_next;
    logic                  is_free;

    assign is_free = (finish <= {{(ralloc_pkg::TIME_W-ralloc_pkg::IN_TIME_W){1'b0}},
                                 start_time});

    always_comb begin
        res_next = res_reg;
        if (beat.vld) begin
            if (beat.first) begin
                res_next.found      = is_free;
                res_next.free_idx   = beat.idx;
                res_next.free_uses  = uses;
                res_next.min_idx    = beat.idx;
                res_next.min_finish = finish;
                res_next.min_uses   = uses;
                res_next.best_idx   = beat.idx;
                res_next.best_uses  = uses;
            end else begin
                if (!res_reg.found && is_free) begin
                    res_next.found     = 1'b1;
                    res_next.free_idx  = beat.idx;
                    res_next.free_uses = uses;
                end
                if (finish < res_reg.min_finish) begin
                    res_next.min_idx    = beat.idx;
                    res_next.min_finish = finish;
                    res_next.min_uses   = uses;
                end
                if (uses > res_reg.best_uses) begin
                    res_next.best_idx  = beat.idx;
                    res_next.best_uses = uses;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            res_reg.found <= 1'b0;
        end else begin
            res_reg.found <= res_next.found;
        end
        res_reg.free_idx   <= res_next.free_idx;
        res_reg.free_uses  <= res_next.free_uses;
        res_reg.min_idx    <= res_next.min_idx;
        res_reg.min_finish <= res_next.min_finish;
        res_reg.min_uses   <= res_next.min_uses;
        res_reg.best_idx   <= res_next.best_idx;
        res_reg.best_uses  <= res_next.best_uses;
    end

    assign res = res_reg;

endmodule

// ===== rtl/core/room_allocator_with_delay.sv =====
// ----------------------------------------------------------------------------
// room_allocator_with_delay
// Greedy meeting room allocator with delay when every room is busy.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (s_*): one meeting per beat, start and end time, with
//   s_new_batch set on the first meeting of a batch to clear every room's
//   finish time and use count. Meetings are expected in start order.
//   Result channel (m_*): one beat per meeting, giving the room, the delay
//   flag, the actual start and end (48 bit, end saturating) and the
//   lowest-index most-used active room.
//   Config: cfg_wr_en / cfg_wr_data write num_rooms (0 acts as 1, values
//   above the built room count act as that count). Write only while idle.
// Timing:
//   A meeting's result follows its accept after the scan: one read of the
//   room memory per active room, then a fold of the last read into the
//   scan, then an update/write-back step. s_ready rises together with
//   m_valid, so a new meeting is only taken once the previous one is
//   through; the single memory read port sets that pace. s_ready is high
//   only between meetings.
// Reset: all rooms read as finish 0 and count 0 (per-room valid bits),
//   num_rooms returns to 16, m_valid drops and s_ready is high.
// Stall: the result sits in an output register; the next meeting is taken
//   and scanned meanwhile, and only its write-back waits for m_ready.
// ----------------------------------------------------------------------------
module room_allocator_with_delay (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // configuration
    input  logic                                  cfg_wr_en,
    input  logic [ralloc_pkg::NUM_W-1:0]          cfg_wr_data,
    // meeting in
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic                                  s_new_batch,
    input  logic [ralloc_pkg::IN_TIME_W-1:0]      s_start_time,
    input  logic [ralloc_pkg::IN_TIME_W-1:0]      s_end_time,
    // allocation out
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic [ralloc_pkg::ROOM_OUT_W-1:0]     m_room,
    output logic                                  m_delayed,
    output logic [ralloc_pkg::TIME_W-1:0]         m_actual_start,
    output logic [ralloc_pkg::TIME_W-1:0]         m_actual_end,
    output logic [ralloc_pkg::ROOM_OUT_W-1:0]     m_busiest_room
);

    localparam int RW = ralloc_pkg::ROOM_W;
    localparam int TW = ralloc_pkg::TIME_W;
    localparam int UW = ralloc_pkg::USES_W;
    localparam int IW = ralloc_pkg::IN_TIME_W;
    localparam int OW = ralloc_pkg::ROOM_OUT_W;

    // sequencer states
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_UPD  = 2'd2;

    logic [1:0] state_reg, state_next;

    // config
    logic [ralloc_pkg::NUM_W-1:0] num_rooms_reg;
    logic [RW-1:0]                n_last_reg, n_last_next;

    // meeting held for the whole scan
    logic [IW-1:0] start_reg, end_reg;
    logic [IW-1:0] dur_reg;

    // per-room valid bits: an entry not yet written since the last clear
    // reads as finish 0, count 0
    logic [ralloc_pkg::MAX_ROOMS-1:0] valid_reg, valid_next;

    // read side
    logic          issuing_reg, issuing_next;
    logic [RW-1:0] rd_idx_reg, rd_idx_next;
    logic          issue;
    ralloc_pkg::beat_t beat_reg, beat_next;
    logic          beat_ok_reg;
    logic [ralloc_pkg::ENTRY_W-1:0] rdata;
    logic [TW-1:0] rd_finish;
    logic [UW-1:0] rd_uses;

    ralloc_pkg::scan_res_t scan_res;

    // update
    logic          in_accept;
    logic          out_load;
    logic [RW-1:0] pick;
    logic [UW-1:0] pick_uses;
    logic [UW-1:0] uses_new;
    logic [TW:0]   delay_sum;
    logic [TW-1:0] a_start, a_end;
    logic [RW-1:0] busiest;
    logic [RW+OW-1:0] pick_ext, busiest_ext;

    // output register
    logic          m_valid_reg, m_valid_next;
    logic [OW-1:0] m_room_reg, m_busiest_reg;
    logic          m_delayed_reg;
    logic [TW-1:0] m_start_reg, m_end_reg;

    assign in_accept = s_valid && s_ready;
    assign s_ready   = (state_reg == ST_IDLE);
    assign out_load  = (state_reg == ST_UPD) && (!m_valid_reg || m_ready);
    assign issue     = (state_reg == ST_SCAN) && issuing_reg;

    // clamp the room count into 1..MAX_ROOMS, kept as last index
    always_comb begin
        if (num_rooms_reg == '0) begin
            n_last_next = '0;
        end else if (32'(num_rooms_reg) > 32'(ralloc_pkg::MAX_ROOMS)) begin
            n_last_next = RW'(ralloc_pkg::MAX_ROOMS - 1);
        end else begin
            n_last_next = RW'(num_rooms_reg - 1'b1);
        end
    end

    // ---------------- room memory: {finish, uses} per room ----------------
    ralloc_ram #(
        .WIDTH (ralloc_pkg::ENTRY_W),
        .DEPTH (ralloc_pkg::MAX_ROOMS)
    ) u_ram (
        .aclk  (aclk),
        .we    (out_load),
        .waddr (pick),
        .wdata ({a_end, uses_new}),
        .re    (issue),
        .raddr (rd_idx_reg),
        .rdata (rdata)
    );

    assign rd_finish = beat_ok_reg ? rdata[ralloc_pkg::ENTRY_W-1:UW] : '0;
    assign rd_uses   = beat_ok_reg ? rdata[UW-1:0] : '0;

    ralloc_scan u_scan (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .beat       (beat_reg),
        .finish     (rd_finish),
        .uses       (rd_uses),
        .start_time (start_reg),
        .res        (scan_res)
    );

    // ---------------- sequencer ----------------
    always_comb begin
        state_next   = state_reg;
        issuing_next = issuing_reg;
        rd_idx_next  = rd_idx_reg;
        valid_next   = valid_reg;

        beat_next.vld   = issue;
        beat_next.idx   = rd_idx_reg;
        beat_next.first = (rd_idx_reg == '0);
        beat_next.last  = (rd_idx_reg == n_last_reg);

        unique case (state_reg)
            ST_IDLE: begin
                if (in_accept) begin
                    state_next   = ST_SCAN;
                    issuing_next = 1'b1;
                    rd_idx_next  = '0;
                    if (s_new_batch) begin
                        valid_next = '0;
                    end
                end
            end
            ST_SCAN: begin
                if (issue) begin
                    if (rd_idx_reg == n_last_reg) begin
                        issuing_next = 1'b0;
                    end else begin
                        rd_idx_next = rd_idx_reg + 1'b1;
                    end
                end
                if (beat_reg.vld && beat_reg.last) begin
                    state_next = ST_UPD;
                end
            end
            ST_UPD: begin
                if (out_load) begin
                    state_next       = ST_IDLE;
                    valid_next[pick] = 1'b1;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ---------------- update: pick the room, times, counts ----------------
    always_comb begin
        if (scan_res.found) begin
            pick      = scan_res.free_idx;
            pick_uses = scan_res.free_uses;
        end else begin
            pick      = scan_res.min_idx;
            pick_uses = scan_res.min_uses;
        end

        uses_new = (pick_uses == ralloc_pkg::USES_MAX) ? pick_uses : pick_uses + 1'b1;

        delay_sum = {1'b0, scan_res.min_finish} + (TW+1)'(dur_reg);
        if (scan_res.found) begin
            a_start = TW'(start_reg);
            a_end   = TW'(end_reg);
        end else begin
            a_start = scan_res.min_finish;
            a_end   = delay_sum[TW] ? ralloc_pkg::TIME_MAX : delay_sum[TW-1:0];
        end

        // only the picked room's count moved, so the argmax is patched
        if (pick == scan_res.best_idx) begin
            busiest = scan_res.best_idx;
        end else if ((uses_new > scan_res.best_uses) ||
                     ((uses_new == scan_res.best_uses) && (pick < scan_res.best_idx))) begin
            busiest = pick;
        end else begin
            busiest = scan_res.best_idx;
        end

        pick_ext    = {{OW{1'b0}}, pick};
        busiest_ext = {{OW{1'b0}}, busiest};
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    // ---------------- registers ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            issuing_reg   <= 1'b0;
            rd_idx_reg    <= '0;
            valid_reg     <= '0;
            beat_reg      <= '0;
            m_valid_reg   <= 1'b0;
            num_rooms_reg <= ralloc_pkg::NUM_RESET;
            n_last_reg    <= '0;
        end else begin
            state_reg   <= state_next;
            issuing_reg <= issuing_next;
            rd_idx_reg  <= rd_idx_next;
            valid_reg   <= valid_next;
            beat_reg    <= beat_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en) begin
                num_rooms_reg <= cfg_wr_data;
            end
            if (in_accept) begin
                n_last_reg <= n_last_next;
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (in_accept) begin
            start_reg <= s_start_time;
            end_reg   <= s_end_time;
            dur_reg   <= (s_end_time >= s_start_time) ? (s_end_time - s_start_time) : '0;
        end
        beat_ok_reg <= valid_reg[rd_idx_reg];
        if (out_load) begin
            m_room_reg    <= pick_ext[OW-1:0];
            m_delayed_reg <= !scan_res.found;
            m_start_reg   <= a_start;
            m_end_reg     <= a_end;
            m_busiest_reg <= busiest_ext[OW-1:0];
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_room         = m_room_reg;
    assign m_delayed      = m_delayed_reg;
    assign m_actual_start = m_start_reg;
    assign m_actual_end   = m_end_reg;
    assign m_busiest_room = m_busiest_reg;

    // ---------------- checks ----------------
    a_pick_active: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> (pick <= n_last_reg))
        else $error("picked room outside active range");

    a_busiest_active: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> (busiest <= n_last_reg))
        else $error("busiest room outside active range");

    a_beat_in_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        beat_reg.vld |-> (state_reg == ST_SCAN))
        else $error("read beat outside scan");

    a_delay_no_wrap: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_load && !scan_res.found) |-> (a_end >= a_start))
        else $error("delayed end wrapped");

    a_batch_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_accept && s_new_batch) |=> (valid_reg == '0))
        else $error("new batch did not clear rooms");

endmodule
